// ===== design/lztd_pkg.sv =====
// Shared constants for the LZ77 token decoder.
// No dependencies; imported by lztd_hist_mem and lz77_token_decoder_unit.
package lztd_pkg;

  localparam int BYTE_W           = 8;
  localparam int LEN_W            = 8;
  localparam int OFF_W            = 16;
  localparam int COUNT_W          = 3;
  localparam int OUT_LANES        = 4;
  localparam int LANE_W           = $clog2(OUT_LANES);
  localparam int OFFSET_RADIX     = 128;
  localparam int WINDOW_DEPTH_DEF = 16384;

endpackage

// ===== design/lztd_hist_mem.sv =====
// History window storage: one write port, one read port, registered read data.
// Depends on lztd_pkg for the byte width.
module lztd_hist_mem #(
  parameter int DEPTH = lztd_pkg::WINDOW_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lztd_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lztd_pkg::BYTE_W-1:0] rd_data
);
  import lztd_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-during-write to the same entry returns the old contents; the
  // decoder forwards the new byte itself.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/lz77_token_decoder_unit.sv =====
// LZ77 token decoder top level: token parser, copy sequencer and output register.
// Depends on lztd_pkg and lztd_hist_mem.
//
// The decoder takes the compressed stream one byte per input transaction.
// Every token is three bytes: offset high H, offset low L (full 8 bits) and
// length N, with offset = H*128 + L. Offset 0 with length 0 announces a
// literal byte, which comes as the next input transaction and is sent out as
// a one-byte word. Any other valid token copies N bytes starting offset bytes
// back in the history window (overlapping copies repeat recent bytes) and
// sends them as words of up to four bytes; out_last marks the final word of
// each run. A zero offset with nonzero length, or an offset larger than the
// number of bytes decoded so far (capped at the window depth), produces one
// word with bad_token and out_last set and out_count zero. A valid offset
// with zero length produces nothing. Timing: header bytes are taken one per
// cycle, and a literal byte is taken once the output register has room.
// A copy holds off input until its last byte is written back, because the history
// sits in a synchronous memory with one read and one write port and registered
// read data that delivers one byte per cycle while the output is not stalled; a
// result word stalled at the output holds the copy where it is. The history needs
// no clearing pass after reset: a valid token never reaches an unwritten entry.
module lz77_token_decoder_unit #(
  parameter int WINDOW_DEPTH = lztd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lztd_pkg::BYTE_W-1:0]  in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lztd_pkg::BYTE_W-1:0]  out_byte0,
  output logic [lztd_pkg::BYTE_W-1:0]  out_byte1,
  output logic [lztd_pkg::BYTE_W-1:0]  out_byte2,
  output logic [lztd_pkg::BYTE_W-1:0]  out_byte3,
  output logic [lztd_pkg::COUNT_W-1:0] out_count,
  output logic                         out_last,
  output logic                         bad_token
);
  import lztd_pkg::*;

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int PC_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = ((OFF_W > PC_W) ? OFF_W : PC_W) + 1;

  typedef enum logic [2:0] {
    ST_HIGH,
    ST_LOW,
    ST_LEN,
    ST_LIT,
    ST_COPY
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] off_high;
  logic [BYTE_W-1:0] off_low;
  logic [AW-1:0]     wp;
  logic [PC_W-1:0]   pc;
  logic [AW-1:0]     rp;
  logic [LEN_W-1:0]  rd_left;
  logic              b_valid;
  logic              b_last;
  logic              fwd_hit;
  logic [BYTE_W-1:0] fwd_data;
  logic [LANE_W-1:0] fill;
  logic [BYTE_W-1:0] lanes    [OUT_LANES];
  logic [BYTE_W-1:0] out_word [OUT_LANES];

  logic              go;
  logic              in_acc;
  logic [OFF_W-1:0]  tok_off;
  logic [CMP_W-1:0]  off_ext;
  logic [CMP_W-1:0]  wp_ext;
  logic [CMP_W-1:0]  start_sum;
  logic              off_beyond;
  logic              issue;
  logic              consume;
  logic              emit_copy;
  logic              lit_acc;
  logic              err_acc;
  logic              word_load;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] b_data;
  logic [BYTE_W-1:0] word_next [OUT_LANES];
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     rp_inc;
  logic [PC_W-1:0]   pc_inc;
  logic              mem_wr_en;
  logic [BYTE_W-1:0] mem_wr_data;

  // The output register can take a new word when it is empty or being drained.
  assign go = !out_valid || !out_stall;

  // Header bytes never wait on the output; the length and literal bytes may
  // produce a word and so need room in the output register.
  assign in_stall = (state == ST_COPY) ||
                    (((state == ST_LEN) || (state == ST_LIT)) && !go);
  assign in_acc   = in_valid && !in_stall;
  assign lit_acc  = in_acc && (state == ST_LIT);

  assign tok_off    = OFF_W'(off_high) * OFF_W'(OFFSET_RADIX) + OFF_W'(off_low);
  assign off_ext    = CMP_W'(tok_off);
  assign wp_ext     = CMP_W'(wp);
  assign off_beyond = off_ext > CMP_W'(pc);
  assign start_sum  = (wp_ext >= off_ext) ? (wp_ext - off_ext)
                                          : (wp_ext + CMP_W'(WINDOW_DEPTH) - off_ext);

  // A length byte that ends a malformed token sends the error word.
  assign err_acc   = in_acc && (state == ST_LEN) &&
                     ((tok_off == '0) ? (in_byte != '0) : off_beyond);
  assign word_load = lit_acc || err_acc || emit_copy;

  assign wp_inc = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc = (rp == AW'(WINDOW_DEPTH - 1)) ? '0 : rp + 1'b1;
  assign pc_inc = (pc < PC_W'(WINDOW_DEPTH)) ? pc + 1'b1 : pc;

  // Copy pipeline: a read is issued and its byte waits in registered read data
  // until the output can take it; it is then written back, packed and possibly
  // sent. A byte written to the entry just read (offset one) is forwarded around the memory.
  assign issue     = (state == ST_COPY) && go && (rd_left != '0);
  assign consume   = (state == ST_COPY) && go && b_valid;
  assign b_data    = fwd_hit ? fwd_data : rd_data;
  assign emit_copy = consume && ((fill == LANE_W'(OUT_LANES - 1)) || b_last);

  always_comb begin
    for (int i = 0; i < OUT_LANES; i++) begin
      word_next[i] = (fill == LANE_W'(i)) ? b_data : lanes[i];
    end
  end

  assign mem_wr_en   = consume || lit_acc;
  assign mem_wr_data = consume ? b_data : in_byte;

  lztd_hist_mem #(
    .DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(wp),
    .wr_data(mem_wr_data),
    .rd_en  (issue),
    .rd_addr(rp),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HIGH;
      off_high  <= '0;
      off_low   <= '0;
      wp        <= '0;
      pc        <= '0;
      rp        <= '0;
      rd_left   <= '0;
      b_valid   <= 1'b0;
      b_last    <= 1'b0;
      fwd_hit   <= 1'b0;
      fwd_data  <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      out_count <= '0;
      out_last  <= 1'b0;
      bad_token <= 1'b0;
      for (int i = 0; i < OUT_LANES; i++) begin
        lanes[i]    <= '0;
        out_word[i] <= '0;
      end
    end else begin
      if (go) begin
        out_valid <= word_load;
      end
      case (state)
        ST_HIGH: begin
          if (in_acc) begin
            off_high <= in_byte;
            state    <= ST_LOW;
          end
        end
        ST_LOW: begin
          if (in_acc) begin
            off_low <= in_byte;
            state   <= ST_LEN;
          end
        end
        ST_LEN: begin
          if (in_acc) begin
            if ((tok_off == '0) && (in_byte == '0)) begin
              state <= ST_LIT;
            end else if ((tok_off == '0) || off_beyond) begin
              out_count <= '0;
              out_last  <= 1'b1;
              bad_token <= 1'b1;
              for (int i = 0; i < OUT_LANES; i++) begin
                out_word[i] <= '0;
              end
              state <= ST_HIGH;
            end else if (in_byte == '0) begin
              state <= ST_HIGH;
            end else begin
              rp      <= AW'(start_sum);
              rd_left <= in_byte;
              fill    <= '0;
              for (int i = 0; i < OUT_LANES; i++) begin
                lanes[i] <= '0;
              end
              state <= ST_COPY;
            end
          end
        end
        ST_LIT: begin
          if (in_acc) begin
            wp        <= wp_inc;
            pc        <= pc_inc;
            out_count <= COUNT_W'(1);
            out_last  <= 1'b1;
            bad_token <= 1'b0;
            for (int i = 0; i < OUT_LANES; i++) begin
              out_word[i] <= (i == 0) ? in_byte : '0;
            end
            state <= ST_HIGH;
          end
        end
        ST_COPY: begin
          if (go) begin
            b_valid  <= issue;
            b_last   <= (rd_left == LEN_W'(1));
            fwd_hit  <= consume && (wp == rp);
            fwd_data <= b_data;
          end
          if (issue) begin
            rp      <= rp_inc;
            rd_left <= rd_left - 1'b1;
          end
          if (consume) begin
            wp <= wp_inc;
            pc <= pc_inc;
            if (emit_copy) begin
              out_count <= COUNT_W'(fill) + COUNT_W'(1);
              out_last  <= b_last;
              bad_token <= 1'b0;
              for (int i = 0; i < OUT_LANES; i++) begin
                out_word[i] <= word_next[i];
                lanes[i]    <= '0;
              end
              fill <= '0;
            end else begin
              lanes[fill] <= b_data;
              fill        <= fill + 1'b1;
            end
            if (b_last) begin
              state <= ST_HIGH;
            end
          end
        end
        default: begin
          state <= ST_HIGH;
        end
      endcase
    end
  end

  assign out_byte0 = out_word[0];
  assign out_byte1 = out_word[1];
  assign out_byte2 = out_word[2];
  assign out_byte3 = out_word[3];

`ifndef ASSERT_OFF
  // An error word is empty and closes its run; a data word carries bytes.
  a_word_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bad_token ? ((out_count == '0) && out_last)
                             : ((out_count != '0) && (out_count <= COUNT_W'(OUT_LANES)))))
    else $error("output word has an inconsistent count or flag");

  // The write-back stage only holds a byte while a copy is running.
  a_b_in_copy: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (state == ST_COPY))
    else $error("copy byte pending outside a copy");

  // A copy always has a byte left to read or one waiting to be written back.
  a_copy_progress: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> ((rd_left != '0) || b_valid))
    else $error("copy sequencer stuck with no work");

  // Sending a copy word restarts packing in the first lane.
  a_fill_restart: assert property (@(posedge clk) disable iff (rst)
    emit_copy |=> (fill == '0))
    else $error("lane fill not restarted after a word");

  // The write pointer stays inside the window.
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    32'(wp) < WINDOW_DEPTH)
    else $error("history write pointer out of range");
`endif

endmodule
